### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, sampled on clk and switched off while rst is high.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication into the following cycle.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/pba_pkg.sv
`default_nettype none

package pba_pkg;

  localparam int NUM_PAGES_DEFAULT = 8192;

  localparam int FUNC_W     = 3;
  localparam int ARG_W      = 16;
  localparam int OUT_PAGE_W = 13;
  localparam int STATUS_W   = 2;
  localparam int FAP_W      = 13;
  localparam int NIL_W      = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int BYTE_W     = 8;
  localparam int BIT_W      = 3;

  // Entry to page conversion: floor(x / 13) == (x * RECIP_MULT) >> RECIP_SHIFT
  // for every 16-bit x, since the rounding error of the reciprocal is 8 / (13 * 2^21).
  localparam int ENTRY_DIVISOR = 13;
  localparam int RECIP_SHIFT   = 21;
  localparam int RECIP_W       = 18;
  localparam int RECIP_MULT    = ((2 ** RECIP_SHIFT) + ENTRY_DIVISOR - 1) / ENTRY_DIVISOR;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_MARK_USED  = 3'd0,
    FUNC_MARK_FREE  = 3'd1,
    FUNC_ENTRY_USED = 3'd2,
    FUNC_ENTRY_FREE = 3'd3,
    FUNC_ALLOC      = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_FULL    = 2'd2,
    ST_NIL     = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_ALLOC = 1'd0,
    REG_NIL_ENTRY   = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_MODIFY,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ARG_W-1:0]  page_or_entry;
  } in_item_t;

  typedef struct packed {
    logic                  previous_used;
    logic [OUT_PAGE_W-1:0] page;
    status_t               status;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/page_bitmap_allocator_core.sv
// Channel | Direction | Handshake            | Beat contents
// in      | input     | in_valid / in_ready   | in_data  : func, page_or_entry
// out     | output    | out_valid / out_ready | out_data : previous_used, page, status
// cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// One item is in work at a time. Page marks pass through the check and modify steps to the
// finish step, an illegal page skipping modify; entry marks add a divide step first, and the nil
// entry goes straight to finish. Allocation scans bitmap bytes from first_alloc_page up through
// the single bitmap RAM read port. After reset a clearing pass writes zero to every bitmap byte
// with in_ready low; configuration writes are taken throughout.
// A result waits in the output register; a new beat is accepted while it waits, and the
// next result holds in its final step until the output register is free.
`default_nettype none
`include "assert_macros.svh"

module page_bitmap_allocator_core #(
  parameter int NUM_PAGES = pba_pkg::NUM_PAGES_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire pba_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output pba_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_we,
  input  wire logic [pba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pba_pkg::CFG_W-1:0]      cfg_data
);

  localparam int BYTE_W    = pba_pkg::BYTE_W;
  localparam int BIT_W     = pba_pkg::BIT_W;
  localparam int ARG_W     = pba_pkg::ARG_W;
  localparam int WORDS     = (NUM_PAGES + BYTE_W - 1) / BYTE_W;
  localparam int WORD_AW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int LAST_BITS = NUM_PAGES - BYTE_W * (WORDS - 1);
  localparam int PROD_W    = ARG_W + pba_pkg::RECIP_W;
  localparam int CMP_W     = ARG_W + 1;

  localparam logic [WORD_AW-1:0] LAST_WORD   = WORD_AW'(WORDS - 1);
  localparam logic [CMP_W-1:0]   NUM_PAGES_V = CMP_W'(NUM_PAGES);
  localparam logic [BYTE_W-1:0]  TAIL_USED   = ~BYTE_W'((2 ** LAST_BITS) - 1);
  localparam logic [PROD_W-1:0]  RECIP_V     = PROD_W'(pba_pkg::RECIP_MULT);

  function automatic logic [BIT_W-1:0] low_zero(input logic [BYTE_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

  pba_pkg::state_t    state, state_next;
  logic [WORD_AW-1:0] clr_addr;
  logic [WORD_AW-1:0] addr;
  logic [pba_pkg::FUNC_W-1:0] func_q;
  logic [ARG_W-1:0]   target;
  logic [PROD_W-1:0]  prod;
  logic [BYTE_W-1:0]  wr_word;
  logic               do_write;
  pba_pkg::out_item_t res;
  logic [pba_pkg::FAP_W-1:0] first_alloc_page;
  logic [pba_pkg::NIL_W-1:0] nil_entry;

  logic               mem_we;
  logic [WORD_AW-1:0] mem_waddr;
  logic [BYTE_W-1:0]  mem_wdata;
  logic [WORD_AW-1:0] mem_raddr;
  logic [BYTE_W-1:0]  mem_rdata;

  logic               accept;
  logic               load_out;
  logic               fap_out_of_range;
  logic [WORD_AW-1:0] fap_word;
  logic [BYTE_W-1:0]  head_used;
  logic [BYTE_W-1:0]  scan_word;
  logic               scan_hit;
  logic [BIT_W-1:0]   scan_idx;
  logic [PAGE_W-1:0]  scan_page;
  logic               target_illegal;
  logic [BIT_W-1:0]   tgt_bit;
  logic [BYTE_W-1:0]  tgt_mask;
  logic               set_used;

  pba_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(WORDS)
  ) u_bitmap (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign fap_out_of_range = CMP_W'(first_alloc_page) >= NUM_PAGES_V;
  assign fap_word         = WORD_AW'(first_alloc_page >> BIT_W);
  assign head_used        = BYTE_W'((9'd1 << first_alloc_page[BIT_W-1:0]) - 9'd1);

  // Pages below first_alloc_page and beyond the last page read as used during the scan.
  assign scan_word = mem_rdata
                   | ((addr == fap_word)  ? head_used : '0)
                   | ((addr == LAST_WORD) ? TAIL_USED : '0);
  assign scan_hit  = (scan_word != '1);
  assign scan_idx  = low_zero(scan_word);
  assign scan_page = PAGE_W'({addr, scan_idx});

  assign target_illegal = CMP_W'(target) >= NUM_PAGES_V;
  assign tgt_bit        = target[BIT_W-1:0];
  assign tgt_mask       = BYTE_W'(1) << tgt_bit;
  assign set_used       = (func_q == pba_pkg::FUNC_MARK_USED) ||
                          (func_q == pba_pkg::FUNC_ENTRY_USED);

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = addr;
    mem_wdata  = wr_word;
    mem_raddr  = addr;
    case (state)
      pba_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == LAST_WORD) begin
          state_next = pba_pkg::S_IDLE;
        end
      end
      pba_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        mem_raddr = fap_word;
        if (in_valid) begin
          case (in_data.func)
            pba_pkg::FUNC_MARK_USED,
            pba_pkg::FUNC_MARK_FREE: state_next = pba_pkg::S_CHECK;
            pba_pkg::FUNC_ENTRY_USED,
            pba_pkg::FUNC_ENTRY_FREE: begin
              state_next = (in_data.page_or_entry == nil_entry) ? pba_pkg::S_FINISH
                                                                  : pba_pkg::S_DIV;
            end
            pba_pkg::FUNC_ALLOC: begin
              state_next = fap_out_of_range ? pba_pkg::S_FINISH : pba_pkg::S_SCAN;
            end
            default: state_next = pba_pkg::S_FINISH;
          endcase
        end
      end
      pba_pkg::S_DIV: begin
        state_next = pba_pkg::S_CHECK;
      end
      pba_pkg::S_CHECK: begin
        mem_raddr  = WORD_AW'(target >> BIT_W);
        state_next = target_illegal ? pba_pkg::S_FINISH : pba_pkg::S_MODIFY;
      end
      pba_pkg::S_MODIFY: begin
        state_next = pba_pkg::S_FINISH;
      end
      pba_pkg::S_SCAN: begin
        mem_raddr = addr + WORD_AW'(1);
        if (scan_hit || (addr == LAST_WORD)) begin
          state_next = pba_pkg::S_FINISH;
        end
      end
      pba_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          mem_we     = do_write;
          state_next = pba_pkg::S_IDLE;
        end
      end
      default: state_next = pba_pkg::S_CLEAR;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pba_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      out_valid <= 1'b0;
      first_alloc_page <= '0;
      nil_entry        <= '1;
    end else begin
      if (state == pba_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + WORD_AW'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          pba_pkg::REG_FIRST_ALLOC: first_alloc_page <= cfg_data[pba_pkg::FAP_W-1:0];
          pba_pkg::REG_NIL_ENTRY:   nil_entry <= cfg_data[pba_pkg::NIL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= res;
    end
    case (state)
      pba_pkg::S_IDLE: begin
        if (accept) begin
          func_q   <= in_data.func;
          target   <= in_data.page_or_entry;
          prod     <= PROD_W'(in_data.page_or_entry) * RECIP_V;
          addr     <= fap_word;
          do_write <= 1'b0;
          res.previous_used <= 1'b0;
          res.page          <= '0;
          if (in_data.func == pba_pkg::FUNC_ALLOC) begin
            res.status <= pba_pkg::ST_FULL;
          end else if ((in_data.func == pba_pkg::FUNC_ENTRY_USED ||
                        in_data.func == pba_pkg::FUNC_ENTRY_FREE) &&
                       in_data.page_or_entry == nil_entry) begin
            res.status <= pba_pkg::ST_NIL;
          end else begin
            res.status <= pba_pkg::ST_OK;
          end
        end
      end
      pba_pkg::S_DIV: begin
        target <= ARG_W'(prod >> pba_pkg::RECIP_SHIFT);
      end
      pba_pkg::S_CHECK: begin
        addr <= WORD_AW'(target >> BIT_W);
        if (target_illegal) begin
          res.status <= pba_pkg::ST_ILLEGAL;
        end
      end
      pba_pkg::S_MODIFY: begin
        do_write          <= 1'b1;
        wr_word           <= set_used ? (mem_rdata | tgt_mask) : (mem_rdata & ~tgt_mask);
        res.previous_used <= mem_rdata[tgt_bit];
        res.page          <= pba_pkg::OUT_PAGE_W'(target);
        res.status        <= pba_pkg::ST_OK;
      end
      pba_pkg::S_SCAN: begin
        if (scan_hit) begin
          do_write   <= 1'b1;
          wr_word    <= mem_rdata | (BYTE_W'(1) << scan_idx);
          res.page   <= pba_pkg::OUT_PAGE_W'(scan_page);
          res.status <= pba_pkg::ST_OK;
        end else begin
          addr <= addr + WORD_AW'(1);
        end
      end
      default: ;
    endcase
  end

  // An accepted beat always takes the block out of idle.
  `ASSERT_NXT(a_accept_busy, accept, state != pba_pkg::S_IDLE)
  // The scan never hands out a page below the first allocatable one.
  `ASSERT_IMP(a_scan_floor, state == pba_pkg::S_SCAN && scan_hit,
              CMP_W'(scan_page) >= CMP_W'(first_alloc_page))
  // A set previous bit only comes with a successful mark.
  `ASSERT_IMP(a_prev_ok, load_out && res.previous_used, res.status == pba_pkg::ST_OK)
  // The bitmap is written back only together with a result or during the clearing pass.
  `ASSERT_IMP(a_write_with_result, mem_we, load_out || state == pba_pkg::S_CLEAR)

endmodule

`default_nettype wire

### rtl/pba_ram.sv
`default_nettype none

module pba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### test/tb_page_bitmap_allocator_core.sv
`default_nettype none

module tb_page_bitmap_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pba_pkg::*;

  localparam int NUM_PAGES = NUM_PAGES_DEFAULT;
  // Slowest run: every beat a full bitmap scan plus worst gaps on both sides, then margin.
  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned RECENT_DEPTH = 64;

  localparam logic [FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

  typedef struct packed {
    logic             reg_write;
    logic [FAP_W-1:0] fa;
    logic [NIL_W-1:0] nil;
    in_item_t         item;
    logic             typed;
    out_item_t        result;
  } step_t;

  localparam int DIRECTED_ROWS = 27;
  localparam step_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b0, 13'd0, 16'd0, '{FUNC_ALLOC, 16'hFFFF},      1'b1, '{1'b0, 13'd0, ST_OK}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_ALLOC, 16'd0},         1'b1, '{1'b0, 13'd1, ST_OK}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_MARK_USED, 16'd0},     1'b1, '{1'b1, 13'd0, ST_OK}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_MARK_FREE, 16'd0},     1'b1, '{1'b1, 13'd0, ST_OK}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_MARK_FREE, 16'd0},     1'b1, '{1'b0, 13'd0, ST_OK}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_ALLOC, 16'd0},         1'b1, '{1'b0, 13'd0, ST_OK}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_MARK_USED, 16'd8191},  1'b1, '{1'b0, 13'd8191, ST_OK}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_MARK_USED, 16'd8192},  1'b1, '{1'b0, 13'd0, ST_ILLEGAL}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_MARK_FREE, 16'hFFFF},  1'b1, '{1'b0, 13'd0, ST_ILLEGAL}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_ENTRY_USED, 16'hFFFF}, 1'b1, '{1'b0, 13'd0, ST_NIL}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_ENTRY_FREE, 16'hFFFF}, 1'b1, '{1'b0, 13'd0, ST_NIL}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_ENTRY_USED, 16'hFFFE}, 1'b1, '{1'b0, 13'd5041, ST_OK}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_ENTRY_FREE, 16'hFFFE}, 1'b0, '0},
    '{1'b0, 13'd0, 16'd0, '{FUNC_ENTRY_USED, 16'd0},    1'b1, '{1'b1, 13'd0, ST_OK}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_ENTRY_FREE, 16'd12},   1'b0, '0},
    '{1'b0, 13'd0, 16'd0, '{FUNC_ENTRY_FREE, 16'd13},   1'b0, '0},
    '{1'b0, 13'd0, 16'd0, '{FUNC_SPARE_5, 16'hFFFF},    1'b1, '{1'b0, 13'd0, ST_OK}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_SPARE_6, 16'd0},       1'b1, '{1'b0, 13'd0, ST_OK}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_SPARE_7, 16'hAAAA},    1'b1, '{1'b0, 13'd0, ST_OK}},
    '{1'b1, 13'd8191, 16'd0, '{FUNC_ALLOC, 16'd0},      1'b0, '0},
    '{1'b0, 13'd0, 16'd0, '{FUNC_ALLOC, 16'd0},         1'b1, '{1'b0, 13'd0, ST_FULL}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_MARK_FREE, 16'd8191},  1'b1, '{1'b1, 13'd8191, ST_OK}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_ALLOC, 16'h5555},      1'b1, '{1'b0, 13'd8191, ST_OK}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_ALLOC, 16'd0},         1'b1, '{1'b0, 13'd0, ST_FULL}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_ENTRY_USED, 16'd0},    1'b1, '{1'b0, 13'd0, ST_NIL}},
    '{1'b0, 13'd0, 16'd0, '{FUNC_ENTRY_USED, 16'hFFFF}, 1'b0, '0},
    '{1'b0, 13'd0, 16'd0, '{FUNC_MARK_USED, 16'd4096},  1'b0, '0}
  };

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bit               page_used [NUM_PAGES];
  logic [FAP_W-1:0] first_alloc = '0;
  logic [NIL_W-1:0] nil_value = '1;
  out_item_t        outcomes_due [$];
  int unsigned      recent_pages [$];
  out_item_t        want;
  int unsigned      failures = 0;
  int unsigned      phase_no = 0;
  bit               calm = 1'b0;
  bit               long_hold_due = 1'b0;

  page_bitmap_allocator_core #(
    .NUM_PAGES(NUM_PAGES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic out_item_t apply_to_bitmap(input in_item_t item);
    out_item_t   res;
    int unsigned pg;
    int unsigned p;
    logic        do_touch;
    logic        set_used;
    logic        found;
    res = '0;
    do_touch = 1'b0;
    set_used = 1'b0;
    found = 1'b0;
    pg = item.page_or_entry;
    case (item.func)
      FUNC_MARK_USED, FUNC_MARK_FREE: begin
        do_touch = 1'b1;
        set_used = (item.func == FUNC_MARK_USED);
      end
      FUNC_ENTRY_USED, FUNC_ENTRY_FREE: begin
        if (item.page_or_entry == nil_value) begin
          res.status = ST_NIL;
        end else begin
          do_touch = 1'b1;
          set_used = (item.func == FUNC_ENTRY_USED);
          pg = item.page_or_entry / ENTRY_DIVISOR;
        end
      end
      FUNC_ALLOC: begin
        res.status = ST_FULL;
        for (p = first_alloc; p < NUM_PAGES && !found; p++) begin
          if (!page_used[p]) begin
            page_used[p] = 1'b1;
            res.page = OUT_PAGE_W'(p);
            res.status = ST_OK;
            found = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (do_touch) begin
      if (pg >= NUM_PAGES) begin
        res.status = ST_ILLEGAL;
      end else begin
        res.previous_used = page_used[pg];
        res.page = OUT_PAGE_W'(pg);
        page_used[pg] = set_used;
      end
    end
    return res;
  endfunction

  // Half the page picks come from pages recently touched, so that marks and frees
  // often land on used pages and allocation finds holes.
  function automatic in_item_t random_op();
    in_item_t    it;
    int unsigned pick;
    int unsigned pg;
    int unsigned entry;
    pick = $urandom_range(0, 99);
    if (recent_pages.size() != 0 && $urandom_range(0, 1) == 1)
      pg = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
    else
      pg = $urandom_range(0, NUM_PAGES - 1);
    entry = pg * ENTRY_DIVISOR + $urandom_range(0, ENTRY_DIVISOR - 1);
    if (entry > 16'hFFFF)
      entry = $urandom_range(0, 16'hFFFF);
    if ($urandom_range(0, 7) == 0)
      entry = nil_value;
    if ($urandom_range(0, 9) == 0)
      pg = $urandom_range(NUM_PAGES, 16'hFFFF);
    it.page_or_entry = 16'($urandom);
    if (pick < 22) begin
      it.func = FUNC_MARK_USED;
      it.page_or_entry = 16'(pg);
    end else if (pick < 44) begin
      it.func = FUNC_MARK_FREE;
      it.page_or_entry = 16'(pg);
    end else if (pick < 60) begin
      it.func = FUNC_ENTRY_USED;
      it.page_or_entry = 16'(entry);
    end else if (pick < 76) begin
      it.func = FUNC_ENTRY_FREE;
      it.page_or_entry = 16'(entry);
    end else if (pick < 96) begin
      it.func = FUNC_ALLOC;
    end else begin
      it.func = FUNC_W'($urandom_range(FUNC_SPARE_5, FUNC_SPARE_7));
    end
    return it;
  endfunction

  task automatic issue(input in_item_t item, input logic typed, input out_item_t typed_result);
    out_item_t predicted;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_to_bitmap(item);
    outcomes_due.push_back(typed ? typed_result : predicted);
    if (predicted.status == ST_OK) begin
      recent_pages.push_back(predicted.page);
      if (recent_pages.size() > RECENT_DEPTH)
        void'(recent_pages.pop_front());
    end
  endtask

  task automatic pause_sender(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drops valid and waits on the clock first, so valid never falls and rises in one step.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outcomes_due.size() != 0) @(posedge clk);
  endtask

  task automatic program_allocator(input logic [FAP_W-1:0] fa, input logic [NIL_W-1:0] nil);
    cfg_we <= 1'b1;
    cfg_index <= REG_FIRST_ALLOC;
    cfg_data <= CFG_W'(fa);
    @(posedge clk);
    cfg_index <= REG_NIL_ENTRY;
    cfg_data <= nil;
    @(posedge clk);
    cfg_we <= 1'b0;
    first_alloc = fa;
    nil_value = nil;
  endtask

  task automatic run_phase(input logic [FAP_W-1:0] fa, input logic [NIL_W-1:0] nil,
                           input int unsigned count);
    int unsigned n;
    settle();
    program_allocator(fa, nil);
    for (n = 0; n < count; n++) begin
      if (phase_no == 1 && n == 20)
        long_hold_due = 1'b1;
      if (phase_no == 2 && n == count / 2)
        settle();
      else if (!calm && n % 80 < 50 && $urandom_range(0, 3) == 0)
        pause_sender($urandom_range(1, 16));
      issue(random_op(), 1'b0, '0);
    end
    phase_no++;
  endtask

  initial begin
    int unsigned row;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_FIRST_ALLOC;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < DIRECTED_ROWS; row++) begin
      if (DIRECTED[row].reg_write) begin
        settle();
        program_allocator(DIRECTED[row].fa, DIRECTED[row].nil);
      end else begin
        if ($urandom_range(0, 3) == 0)
          pause_sender($urandom_range(1, 16));
        issue(DIRECTED[row].item, DIRECTED[row].typed, DIRECTED[row].result);
      end
    end

    run_phase(13'd0, 16'hFFFF, 200);
    run_phase(13'd8191, 16'd0, 150);
    run_phase(13'($urandom), 16'($urandom), 250);
    run_phase(13'd8150, 16'($urandom_range(0, 16'hFFFF)), 200);
    run_phase(13'($urandom_range(0, 1023)), 16'hFFFF, 200);
    calm = 1'b1;
    run_phase(13'd0, 16'($urandom), 200);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off so the block backs up onto its input.
  initial begin
    forever begin
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (outcomes_due.size() == 0) begin
        failures++;
        $display("%0t: beat with nothing expected: previous_used %0b page %0d status %0d",
                 $time, out_data.previous_used, out_data.page, out_data.status);
      end else begin
        want = outcomes_due.pop_front();
        if (out_data.previous_used !== want.previous_used) begin
          failures++;
          $display("%0t: previous_used expected %0b, got %0b",
                   $time, want.previous_used, out_data.previous_used);
        end
        if (out_data.page !== want.page) begin
          failures++;
          $display("%0t: page expected %0d, got %0d", $time, want.page, out_data.page);
        end
        if (out_data.status !== want.status) begin
          failures++;
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_data.status);
        end
      end
    end
  end

  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl
rtl/pba_pkg.sv
rtl/pba_ram.sv
rtl/page_bitmap_allocator_core.sv
test/tb_page_bitmap_allocator_core.sv
